[src/dti_pkg.sv]
package dti_pkg;

    localparam int TIME_BITS = 40;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [2:0] {
        PH_IDLE          = 3'd0,
        PH_WAIT_POLL_TX  = 3'd1,
        PH_WAIT_RESP     = 3'd2,
        PH_WAIT_FINAL_TX = 3'd3,
        PH_WAIT_TIMES    = 3'd4
    } phase_t;

    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_TX_DONE  = 3'd1;
    localparam logic [2:0] OP_RX_FRAME = 3'd2;
    localparam logic [2:0] OP_RX_ERROR = 3'd3;
    localparam logic [2:0] OP_ABORT    = 3'd4;

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_SEND     = 2'd1;
    localparam logic [1:0] ACT_RX_EN    = 2'd2;
    localparam logic [1:0] ACT_RST_SEND = 2'd3;

    localparam logic [1:0] REG_POLL_TYPE     = 2'd0;
    localparam logic [1:0] REG_FINAL_TYPE    = 2'd1;
    localparam logic [1:0] REG_RESPONSE_TYPE = 2'd2;

    localparam logic [3:0] POLL_TYPE_RST     = 4'd1;
    localparam logic [3:0] FINAL_TYPE_RST    = 4'd2;
    localparam logic [3:0] RESPONSE_TYPE_RST = 4'd10;

    typedef struct packed {
        logic [2:0] opcode;
        logic [3:0] anchor_id;
        logic [7:0] frame_byte;
        time_t      local_time;
        time_t      remote_t2;
        time_t      remote_t3;
        time_t      remote_t6;
    } evt_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] tx_byte;
        logic       done_res;
        time_t      round_initiator;
        time_t      reply_anchor;
        time_t      round_anchor;
        time_t      reply_initiator;
    } res_t;

endpackage

[src/dti_in_stage.sv]
module dti_in_stage
    import dti_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic evt_valid,
    output logic evt_ready,
    input  evt_t evt_data,
    output logic item_valid,
    output evt_t item,
    input  logic fire
);

    logic valid_reg;
    logic valid_next;
    evt_t data_reg;

    assign evt_ready  = !valid_reg || fire;
    assign valid_next = (evt_valid && evt_ready) || (valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
        begin
            data_reg <= evt_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

[src/dti_core.sv]
module dti_core
    import dti_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_wdata,
    input  logic       fire,
    input  evt_t       item,
    output res_t       result
);

    logic [3:0] poll_type_reg;
    logic [3:0] final_type_reg;
    logic [3:0] response_type_reg;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] anchor_reg;
    time_t      poll_sent_reg;
    time_t      resp_rx_reg;
    time_t      final_sent_reg;

    logic       resp_match;
    logic       times_ok;

    assign resp_match = item.frame_byte == {anchor_reg, response_type_reg};
    assign times_ok   = !((item.remote_t6 < item.remote_t2) || (final_sent_reg < poll_sent_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_type_reg     <= POLL_TYPE_RST;
            final_type_reg    <= FINAL_TYPE_RST;
            response_type_reg <= RESPONSE_TYPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLL_TYPE:     poll_type_reg     <= cfg_wdata;
                REG_FINAL_TYPE:    final_type_reg    <= cfg_wdata;
                REG_RESPONSE_TYPE: response_type_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (item.opcode)
            OP_START:
                phase_next = PH_WAIT_POLL_TX;
            OP_TX_DONE:
                if (phase_reg == PH_WAIT_POLL_TX)
                begin
                    phase_next = PH_WAIT_RESP;
                end
                else if (phase_reg == PH_WAIT_FINAL_TX)
                begin
                    phase_next = PH_WAIT_TIMES;
                end
            OP_RX_FRAME:
                if (phase_reg == PH_WAIT_RESP)
                begin
                    phase_next = resp_match ? PH_WAIT_FINAL_TX : PH_WAIT_POLL_TX;
                end
                else if (phase_reg == PH_WAIT_TIMES)
                begin
                    phase_next = times_ok ? PH_IDLE : PH_WAIT_POLL_TX;
                end
            OP_RX_ERROR:
                if (phase_reg == PH_WAIT_RESP || phase_reg == PH_WAIT_TIMES)
                begin
                    phase_next = PH_WAIT_POLL_TX;
                end
            OP_ABORT:
                phase_next = PH_IDLE;
            default:
                phase_next = phase_reg;
        endcase
    end

    // result
    always_comb
    begin
        result = '0;
        unique case (item.opcode)
            OP_START:
            begin
                result.action  = ACT_SEND;
                result.tx_byte = {poll_type_reg, item.anchor_id};
            end
            OP_TX_DONE:
                if (phase_reg == PH_WAIT_POLL_TX || phase_reg == PH_WAIT_FINAL_TX)
                begin
                    result.action = ACT_RX_EN;
                end
            OP_RX_FRAME:
                if (phase_reg == PH_WAIT_RESP)
                begin
                    result.action  = ACT_SEND;
                    result.tx_byte = resp_match ? {final_type_reg, anchor_reg}
                                                : {poll_type_reg, anchor_reg};
                end
                else if (phase_reg == PH_WAIT_TIMES)
                begin
                    if (times_ok)
                    begin
                        result.done_res        = 1'b1;
                        result.round_initiator = resp_rx_reg - poll_sent_reg;
                        result.reply_anchor    = item.remote_t3 - item.remote_t2;
                        result.round_anchor    = item.remote_t6 - item.remote_t3;
                        result.reply_initiator = final_sent_reg - resp_rx_reg;
                    end
                    else
                    begin
                        result.action  = ACT_SEND;
                        result.tx_byte = {poll_type_reg, anchor_reg};
                    end
                end
            OP_RX_ERROR:
                if (phase_reg == PH_WAIT_RESP || phase_reg == PH_WAIT_TIMES)
                begin
                    result.action  = ACT_RST_SEND;
                    result.tx_byte = {poll_type_reg, anchor_reg};
                end
            default:
                result = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            anchor_reg     <= '0;
            poll_sent_reg  <= '0;
            resp_rx_reg    <= '0;
            final_sent_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            if (item.opcode == OP_START)
            begin
                anchor_reg <= item.anchor_id;
            end
            if (item.opcode == OP_TX_DONE && phase_reg == PH_WAIT_POLL_TX)
            begin
                poll_sent_reg <= item.local_time;
            end
            if (item.opcode == OP_TX_DONE && phase_reg == PH_WAIT_FINAL_TX)
            begin
                final_sent_reg <= item.local_time;
            end
            if (item.opcode == OP_RX_FRAME && phase_reg == PH_WAIT_RESP && resp_match)
            begin
                resp_rx_reg <= item.local_time;
            end
        end
    end

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.done_res |=> phase_reg == PH_IDLE)
        else $error("completed exchange did not return to idle");

    a_start_latches: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.opcode == OP_START
        |=> phase_reg == PH_WAIT_POLL_TX && anchor_reg == $past(item.anchor_id))
        else $error("start did not arm poll to requested anchor");

    a_hold_without_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(anchor_reg))
        else $error("exchange state moved without a transfer");

    a_send_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (result.action == ACT_SEND || result.action == ACT_RST_SEND)
        |-> !result.done_res && phase_next == PH_WAIT_POLL_TX
            || phase_next == PH_WAIT_FINAL_TX)
        else $error("send issued without waiting for its transmit done");

endmodule

[src/dti_out_stage.sv]
module dti_out_stage
    import dti_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    input  res_t result,
    output logic fire,
    output logic res_valid,
    input  logic res_ready,
    output res_t res_data
);

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    assign fire       = item_valid && (!valid_reg || res_ready);
    assign valid_next = fire || (valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= result;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

[src/ds_twr_initiator_exchange.sv]
// channel | handshake            | payload
// --------+----------------------+----------------------------------
// event   | evt_valid/evt_ready  | evt_data (evt_t)
// result  | res_valid/res_ready  | res_data (res_t), one per event
// config  | cfg_we               | cfg_index, cfg_wdata
//
// One event per cycle sustained while res_ready is high; a stalled result backs up both stages.
// Latency is set by the event register and the result register around the phase logic.
// rst_n clears both stages, the phase (idle), anchor and timestamps; config to defaults.
// A stalled result holds the result register; the event register can still take one more event, then holds it.
module ds_twr_initiator_exchange
    import dti_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       evt_valid,
    output logic       evt_ready,
    input  evt_t       evt_data,
    output logic       res_valid,
    input  logic       res_ready,
    output res_t       res_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_wdata
);

    logic item_valid;
    evt_t item;
    res_t result;
    logic fire;

    dti_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt_data   (evt_data),
        .item_valid (item_valid),
        .item       (item),
        .fire       (fire)
    );

    dti_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    dti_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .fire       (fire),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

endmodule

[test/tb_ds_twr_initiator_exchange.sv]
module tb_ds_twr_initiator_exchange;
    import dti_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       evt_valid = 1'b0;
    logic       evt_ready;
    evt_t       evt_data = '0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    res_t       res_data;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [3:0] cfg_wdata = '0;

    evt_t pend_evts[$];
    res_t exp_results[$];
    res_t res_want;
    int   errors = 0;
    int   n_queued = 0;
    int   n_checked = 0;
    bit   calm = 1'b0;
    int   evt_gap = 0;
    int   res_stall = 0;

    // ranging state and register copies
    phase_t     m_phase = PH_IDLE;
    logic [3:0] m_anchor = '0;
    time_t      m_t1 = '0;
    time_t      m_t4 = '0;
    time_t      m_t5 = '0;
    logic [3:0] cfg_poll = POLL_TYPE_RST;
    logic [3:0] cfg_final = FINAL_TYPE_RST;
    logic [3:0] cfg_resp = RESPONSE_TYPE_RST;

    ds_twr_initiator_exchange i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_data  (evt_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        if (r < 98)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic res_t poll_again(logic [1:0] act);
        res_t r;
        r = '0;
        r.action = act;
        r.tx_byte = {cfg_poll, m_anchor};
        m_phase = PH_WAIT_POLL_TX;
        return r;
    endfunction

    function automatic res_t ranging_step(evt_t e);
        res_t r;
        r = '0;
        case (e.opcode)
            OP_START:
            begin
                m_anchor = e.anchor_id;
                r = poll_again(ACT_SEND);
            end
            OP_TX_DONE:
            begin
                if (m_phase == PH_WAIT_POLL_TX)
                begin
                    m_t1 = e.local_time;
                    r.action = ACT_RX_EN;
                    m_phase = PH_WAIT_RESP;
                end
                else if (m_phase == PH_WAIT_FINAL_TX)
                begin
                    m_t5 = e.local_time;
                    r.action = ACT_RX_EN;
                    m_phase = PH_WAIT_TIMES;
                end
            end
            OP_RX_FRAME:
            begin
                if (m_phase == PH_WAIT_RESP)
                begin
                    if (e.frame_byte == {m_anchor, cfg_resp})
                    begin
                        m_t4 = e.local_time;
                        r.action = ACT_SEND;
                        r.tx_byte = {cfg_final, m_anchor};
                        m_phase = PH_WAIT_FINAL_TX;
                    end
                    else
                        r = poll_again(ACT_SEND);
                end
                else if (m_phase == PH_WAIT_TIMES)
                begin
                    if (e.remote_t6 < e.remote_t2 || m_t5 < m_t1)
                        r = poll_again(ACT_SEND);
                    else
                    begin
                        r.done_res = 1'b1;
                        r.round_initiator = m_t4 - m_t1;
                        r.reply_anchor = e.remote_t3 - e.remote_t2;
                        r.round_anchor = e.remote_t6 - e.remote_t3;
                        r.reply_initiator = m_t5 - m_t4;
                        m_phase = PH_IDLE;
                    end
                end
            end
            OP_RX_ERROR:
            begin
                if (m_phase == PH_WAIT_RESP || m_phase == PH_WAIT_TIMES)
                    r = poll_again(ACT_RST_SEND);
            end
            OP_ABORT:
                m_phase = PH_IDLE;
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    // event driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt_valid && evt_ready)
                exp_results.push_back(ranging_step(evt_data));
            if (!evt_valid || evt_ready)
            begin
                if (evt_gap > 0)
                begin
                    evt_gap <= evt_gap - 1;
                    evt_valid <= 1'b0;
                end
                else if (pend_evts.size() > 0)
                begin
                    evt_valid <= 1'b1;
                    evt_data <= pend_evts.pop_front();
                    evt_gap <= pick_gap();
                end
                else
                    evt_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (exp_results.size() == 0)
                begin
                    $error("result transfer with no expectation pending");
                    errors++;
                end
                else
                begin
                    res_want = exp_results.pop_front();
                    check_field("action", 64'(res_want.action), 64'(res_data.action));
                    check_field("tx_byte", 64'(res_want.tx_byte), 64'(res_data.tx_byte));
                    check_field("done_res", 64'(res_want.done_res), 64'(res_data.done_res));
                    check_field("round_initiator", 64'(res_want.round_initiator),
                                64'(res_data.round_initiator));
                    check_field("reply_anchor", 64'(res_want.reply_anchor),
                                64'(res_data.reply_anchor));
                    check_field("round_anchor", 64'(res_want.round_anchor),
                                64'(res_data.round_anchor));
                    check_field("reply_initiator", 64'(res_want.reply_initiator),
                                64'(res_data.reply_initiator));
                    n_checked++;
                end
            end
            if (res_stall > 0)
            begin
                res_stall <= res_stall - 1;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    res_stall <= pick_gap();
            end
        end
    end

    function automatic time_t rnd_time();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return w[TIME_BITS-1:0];
        endcase
    endfunction

    function automatic time_t rnd_delta();
        if ($urandom_range(0, 5) == 0)
            return rnd_time();
        return {8'd0, $urandom_range(0, 32'h00ff_ffff)};
    endfunction

    function automatic evt_t mk_evt(logic [2:0] op);
        evt_t e;
        e.opcode = op;
        e.anchor_id = 4'($urandom_range(0, 15));
        e.frame_byte = 8'($urandom_range(0, 255));
        e.local_time = rnd_time();
        e.remote_t2 = rnd_time();
        e.remote_t3 = rnd_time();
        e.remote_t6 = rnd_time();
        return e;
    endfunction

    task automatic push(evt_t e);
        pend_evts.push_back(e);
        n_queued++;
    endtask

    task automatic push_fixed(logic [2:0] op, logic [3:0] a, logic [7:0] fb, time_t lt,
                              time_t t2, time_t t3, time_t t6);
        evt_t e;
        e.opcode = op;
        e.anchor_id = a;
        e.frame_byte = fb;
        e.local_time = lt;
        e.remote_t2 = t2;
        e.remote_t3 = t3;
        e.remote_t6 = t6;
        push(e);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 11) == 0)
            push(mk_evt(3'($urandom_range(0, 7))));
    endtask

    // one ranging exchange with random times, sometimes disturbed
    task automatic push_exchange();
        logic [3:0] a;
        time_t t1, t4, t5, t2, t3, t6;
        evt_t e;
        a = 4'($urandom_range(0, 15));
        t1 = rnd_time();
        t4 = t1 + rnd_delta();
        t5 = t4 + rnd_delta();
        t2 = rnd_time();
        t3 = t2 + rnd_delta();
        t6 = t3 + rnd_delta();
        e = mk_evt(OP_START);
        e.anchor_id = a;
        push(e);
        maybe_noise();
        e = mk_evt(OP_TX_DONE);
        e.local_time = t1;
        push(e);
        if ($urandom_range(0, 9) == 0)
        begin
            e = mk_evt($urandom_range(0, 1) ? OP_RX_FRAME : OP_RX_ERROR);
            e.frame_byte = {a, cfg_resp} ^ 8'(1 << $urandom_range(0, 7));
            push(e);
            e = mk_evt(OP_TX_DONE);
            e.local_time = t1;
            push(e);
        end
        maybe_noise();
        e = mk_evt(OP_RX_FRAME);
        e.frame_byte = {a, cfg_resp};
        e.local_time = t4;
        push(e);
        maybe_noise();
        e = mk_evt(OP_TX_DONE);
        e.local_time = t5;
        push(e);
        maybe_noise();
        e = mk_evt(OP_RX_FRAME);
        e.remote_t2 = t2;
        e.remote_t3 = t3;
        e.remote_t6 = t6;
        push(e);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POLL_TYPE:     cfg_poll = val;
            REG_FINAL_TYPE:    cfg_final = val;
            REG_RESPONSE_TYPE: cfg_resp = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (n_checked < n_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int n_target;
        logic [3:0] vp, vf, vr;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_fixed(OP_TX_DONE, 4'd0, 8'd0, '1, '0, '0, '0);
        push_fixed(3'd7, 4'hf, 8'hff, '1, '1, '1, '1);
        push_fixed(OP_START, 4'd0, 8'd0, '0, '0, '0, '0);
        push_fixed(OP_START, 4'hf, 8'd0, '0, '0, '0, '0);
        push_fixed(OP_TX_DONE, 4'd0, 8'd0, '0, '0, '0, '0);
        push_fixed(OP_RX_FRAME, 4'd0, 8'h05, '0, '0, '0, '0);
        push_fixed(OP_TX_DONE, 4'd0, 8'd0, '1, '0, '0, '0);
        push_fixed(OP_RX_ERROR, 4'd0, 8'd0, '0, '0, '0, '0);
        push_fixed(OP_TX_DONE, 4'd0, 8'd0, '0, '0, '0, '0);
        push_fixed(OP_RX_FRAME, 4'd0, {4'hf, cfg_resp}, '1, '0, '0, '0);
        push_fixed(OP_RX_ERROR, 4'd0, 8'd0, '0, '0, '0, '0);
        push_fixed(OP_TX_DONE, 4'd0, 8'd0, '1, '0, '0, '0);
        // anchor times out of order
        push_fixed(OP_RX_FRAME, 4'd0, 8'd0, '0, '1, '0, '0);
        push_fixed(OP_TX_DONE, 4'd0, 8'd0, '1, '0, '0, '0);
        push_fixed(OP_RX_FRAME, 4'd0, {4'hf, cfg_resp}, '0, '0, '0, '0);
        push_fixed(OP_TX_DONE, 4'd0, 8'd0, '0, '0, '0, '0);
        // local times out of order
        push_fixed(OP_RX_FRAME, 4'd0, 8'd0, '0, '0, '1, '1);
        push_fixed(OP_TX_DONE, 4'd0, 8'd0, '0, '0, '0, '0);
        push_fixed(OP_RX_FRAME, 4'd0, {4'hf, cfg_resp}, '1, '0, '0, '0);
        push_fixed(OP_TX_DONE, 4'd0, 8'd0, '1, '0, '0, '0);
        push_fixed(OP_RX_FRAME, 4'd0, 8'd0, '0, '0, '1, '1);
        push_fixed(OP_ABORT, 4'd0, 8'd0, '0, '0, '0, '0);
        push_fixed(OP_START, 4'd3, 8'd0, '0, '0, '0, '0);
        push_fixed(OP_ABORT, 4'd0, 8'd0, '0, '0, '0, '0);
        push_fixed(OP_RX_FRAME, 4'd0, 8'hff, '0, '0, '0, '0);
        push_fixed(OP_RX_ERROR, 4'd0, 8'd0, '0, '0, '0, '0);
        drain();

        for (int ph = 1; ph <= 7; ph++)
        begin
            case (ph)
                1:
                begin
                    vp = 4'h0;
                    vf = 4'h0;
                    vr = 4'h0;
                end
                2:
                begin
                    vp = 4'hf;
                    vf = 4'hf;
                    vr = 4'hf;
                end
                7:
                begin
                    vp = POLL_TYPE_RST;
                    vf = FINAL_TYPE_RST;
                    vr = RESPONSE_TYPE_RST;
                end
                default:
                begin
                    vp = 4'($urandom_range(0, 15));
                    vf = 4'($urandom_range(0, 15));
                    vr = 4'($urandom_range(0, 15));
                end
            endcase
            write_reg(REG_POLL_TYPE, vp);
            write_reg(REG_FINAL_TYPE, vf);
            write_reg(REG_RESPONSE_TYPE, vr);
            calm = ($urandom_range(0, 3) == 0);
            n_target = n_queued + 100;
            while (n_queued < n_target)
                push_exchange();
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
src/dti_pkg.sv
src/dti_in_stage.sv
src/dti_core.sv
src/dti_out_stage.sv
src/ds_twr_initiator_exchange.sv
test/tb_ds_twr_initiator_exchange.sv
